// ===== rtl/dldd_pkg.sv =====
// shared types, codes and sizes of the decimal list parser with dedup
package dldd_pkg;

	localparam int SET_DEPTH = 64;
	localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CNT_W = $clog2(SET_DEPTH + 1);
	localparam int VAL_W = 32;

	// item opcodes
	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_DUP    = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [VAL_W-1:0] value;
		logic [5:0]       slot;
		logic [7:0]       dup_count;
		logic [6:0]       set_size;
		logic             last;
	} result_t;

	// lookup token walking along the cell row
	typedef struct packed {
		logic             active;
		logic             found;
		logic [IDX_W-1:0] slot;
	} probe_t;

	// store request into one cell
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} wr_t;

endpackage

// ===== rtl/dldd_cell.sv =====
// one set entry: holds a value and checks the passing lookup token against it
module dldd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dldd_pkg::IDX_W-1:0] idx,
	input  logic [dldd_pkg::CNT_W-1:0] count,
	input  logic [dldd_pkg::VAL_W-1:0] key,
	input  dldd_pkg::wr_t              wr,
	input  dldd_pkg::probe_t           probe_in,
	output dldd_pkg::probe_t           probe_out
);

	logic [dldd_pkg::VAL_W-1:0] value_q;
	logic                       hit;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == idx)) begin
			value_q <= wr.data;
		end
	end

	// only entries below the fill count take part
	assign hit = probe_in.active && !probe_in.found &&
		(dldd_pkg::CNT_W'(idx) < count) && (value_q == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out.active <= probe_in.active;
			probe_out.found  <= probe_in.found | hit;
			probe_out.slot   <= hit ? idx : probe_in.slot;
		end
	end

endmodule

// ===== rtl/decimal_list_parser_with_dedup_unit.sv =====
// top level: tokenizer, control and the row of set cells
//
//  channel | signals                | direction | transaction
//  --------+------------------------+-----------+----------------------------------
//  item    | start, busy, item      | in        | start high while busy low
//  result  | strobe, result         | out       | strobe high for one cycle
//
// busy: a character byte that closes nothing, a clear, an unused opcode, or an
//   end item with nothing to look up never raises busy
// a separator that closes a number, or an end item that closes a number or ends
//   an empty string, launches a lookup token that walks the SET_DEPTH cells one
//   cell per cycle: busy stays high until the token has left the last cell
//   (for an end item also through ST_DONE, which adds the string done result)
// the next item can be taken at the first edge with busy low
// reset: arst_n clears the fill count, the per-string state and the token;
//   the stored values are not cleared, entries at or past the count are ignored
// stalls: the receiver cannot stall; each result is driven for one cycle
module decimal_list_parser_with_dedup_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dldd_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output dldd_pkg::result_t result
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	localparam int DEPTH = dldd_pkg::SET_DEPTH;
	localparam int IW    = dldd_pkg::IDX_W;
	localparam int CW    = dldd_pkg::CNT_W;
	localparam int VW    = dldd_pkg::VAL_W;

	logic [1:0]    state_q;
	logic          launch_q;
	logic          strobe_q;
	logic          end_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [VW-1:0] acc_q;
	logic          in_num_q;
	logic          saw_q;
	logic [7:0]    dup_q;
	logic [VW-1:0] key_q;
	dldd_pkg::result_t res_q;

	// token row: chain[0] feeds the first cell, chain[DEPTH] leaves the last
	dldd_pkg::probe_t chain [DEPTH+1];
	logic [DEPTH-1:0] act;
	dldd_pkg::wr_t    wr;

	logic          accept;
	logic          is_digit;
	logic [VW+3:0] acc_x10;
	logic [VW-1:0] acc_next;
	logic          tail_done;
	logic          full;
	logic [7:0]    dup_next;
	logic [CW-1:0] count_next;
	dldd_pkg::result_t comp_res;
	dldd_pkg::result_t done_res;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	// digit step: acc * 10 + digit, saturating at all ones
	always_comb begin
		is_digit = item.ch inside {[dldd_pkg::CH_ZERO:dldd_pkg::CH_NINE]};
		acc_x10  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
			(VW+4)'(item.ch[3:0]);
		acc_next = (acc_x10[VW+3:VW] != 4'd0) ? dldd_pkg::VAL_MAX : acc_x10[VW-1:0];
	end

	assign chain[0].active = launch_q;
	assign chain[0].found  = 1'b0;
	assign chain[0].slot   = '0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			dldd_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.idx       (IW'(g)),
				.count     (count_q),
				.key       (key_q),
				.wr        (wr),
				.probe_in  (chain[g]),
				.probe_out (chain[g+1])
			);
			assign act[g] = chain[g+1].active;
		end
	endgenerate

	// lookup outcome once the token leaves the last cell
	always_comb begin
		tail_done  = (state_q == ST_SEARCH) && chain[DEPTH].active;
		full       = (count_q >= CW'(DEPTH));
		dup_next   = dup_q;
		count_next = count_q;
		wr.en      = 1'b0;
		wr.idx     = count_q[IW-1:0];
		wr.data    = key_q;

		comp_res.value     = key_q;
		comp_res.last      = last_q;
		if (chain[DEPTH].found) begin
			dup_next       = dup_q + 8'd1;
			comp_res.kind  = dldd_pkg::KIND_DUP;
			comp_res.slot  = 6'(chain[DEPTH].slot);
		end else if (full) begin
			comp_res.kind  = dldd_pkg::KIND_FULL;
			comp_res.slot  = 6'd0;
		end else begin
			wr.en          = tail_done;
			count_next     = count_q + CW'(1);
			comp_res.kind  = dldd_pkg::KIND_APPEND;
			comp_res.slot  = 6'(count_q);
		end
		comp_res.dup_count = dup_next;
		comp_res.set_size  = 7'(count_next);

		done_res.kind      = dldd_pkg::KIND_DONE;
		done_res.value     = '0;
		done_res.slot      = 6'd0;
		done_res.dup_count = dup_q;
		done_res.set_size  = 7'(count_q);
		done_res.last      = 1'b1;
	end

	// control and per-string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			strobe_q <= 1'b0;
			end_q    <= 1'b0;
			count_q  <= '0;
			acc_q    <= '0;
			in_num_q <= 1'b0;
			saw_q    <= 1'b0;
			dup_q    <= '0;
		end else begin
			launch_q <= 1'b0;
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.opcode)
							dldd_pkg::OP_CHAR: begin
								saw_q <= 1'b1;
								if (is_digit) begin
									acc_q    <= acc_next;
									in_num_q <= 1'b1;
								end else if (in_num_q) begin
									// separator closes the open number
									end_q    <= 1'b0;
									launch_q <= 1'b1;
									state_q  <= ST_SEARCH;
									acc_q    <= '0;
									in_num_q <= 1'b0;
								end
							end
							dldd_pkg::OP_END: begin
								acc_q    <= '0;
								in_num_q <= 1'b0;
								if (in_num_q || !saw_q) begin
									// open number, or empty string inserting zero
									end_q    <= 1'b1;
									launch_q <= 1'b1;
									state_q  <= ST_SEARCH;
								end else begin
									strobe_q <= 1'b1;
									saw_q    <= 1'b0;
									dup_q    <= '0;
								end
							end
							dldd_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (tail_done) begin
						strobe_q <= 1'b1;
						dup_q    <= dup_next;
						count_q  <= count_next;
						state_q  <= end_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_DONE: begin
					strobe_q <= 1'b1;
					saw_q    <= 1'b0;
					dup_q    <= '0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= (item.opcode == dldd_pkg::OP_END && !in_num_q) ? '0 : acc_q;
			last_q <= (item.opcode == dldd_pkg::OP_CHAR);
		end
		if (state_q == ST_IDLE && accept && item.opcode == dldd_pkg::OP_END) begin
			res_q <= done_res;
		end else if (tail_done) begin
			res_q <= comp_res;
		end else if (state_q == ST_DONE) begin
			res_q <= done_res;
		end
	end

	// at most one token in the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({act, launch_q}))
		else $error("more than one lookup token in the cell row");

	a_token_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(launch_q || chain[DEPTH].active) |-> (state_q == ST_SEARCH))
		else $error("lookup token outside a search");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count past set depth");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && res_q.kind == dldd_pkg::KIND_DONE) |-> res_q.last)
		else $error("string done result without last");

	a_search_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		tail_done |=> strobe_q)
		else $error("finished lookup gave no result");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the decimal list parser with dedup: directed and random byte strings
`timescale 1ns / 1ps

module tb_top;

	// opcode with no function in the block, sent to check that it is ignored
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// slowest legal run is far below this: ~1060 items, each closing a number
	// (busy through a whole lookup) plus sender gaps in the busiest idle phase
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned TAIL_CYCLES = dldd_pkg::SET_DEPTH + 16;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	dldd_pkg::item_t   item = '0;
	logic              busy;
	logic              strobe;
	dldd_pkg::result_t result;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_pct = 12;

	// mirror of the parser state, advanced once per accepted transaction
	logic [dldd_pkg::VAL_W-1:0] set_copy [dldd_pkg::SET_DEPTH];
	int unsigned                set_fill = 0;
	logic [dldd_pkg::VAL_W-1:0] num_acc = '0;
	bit                         num_open = 1'b0;
	bit                         string_started = 1'b0;
	logic [7:0]                 dup_tally = '0;

	// reports the block still owes, oldest first
	dldd_pkg::result_t lookup_reports [$];

	decimal_list_parser_with_dedup_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// queue one report, taking the running tallies as they stand now
	function automatic void record_report(input logic [1:0] k,
			input logic [dldd_pkg::VAL_W-1:0] v, input int unsigned pos, input bit fin);
		dldd_pkg::result_t r;
		r.kind      = k;
		r.value     = v;
		r.slot      = 6'(pos);
		r.dup_count = dup_tally;
		r.set_size  = 7'(set_fill);
		r.last      = fin;
		lookup_reports.push_back(r);
	endfunction

	// a number has ended: find it in the set, append it, or drop it when full
	function automatic void probe_set(input logic [dldd_pkg::VAL_W-1:0] v, input bit fin);
		for (int i = 0; i < set_fill; i++) begin
			if (set_copy[i] == v) begin
				dup_tally++;
				record_report(dldd_pkg::KIND_DUP, v, i, fin);
				return;
			end
		end
		if (set_fill >= dldd_pkg::SET_DEPTH) begin
			record_report(dldd_pkg::KIND_FULL, v, 0, fin);
			return;
		end
		set_copy[set_fill] = v;
		set_fill++;
		record_report(dldd_pkg::KIND_APPEND, v, set_fill - 1, fin);
	endfunction

	function automatic void parse_and_lookup(input dldd_pkg::item_t it);
		logic [35:0] grown;
		case (it.opcode)
			dldd_pkg::OP_CHAR: begin
				string_started = 1'b1;
				if (it.ch >= dldd_pkg::CH_ZERO && it.ch <= dldd_pkg::CH_NINE) begin
					// digit: accumulate, pinned at the top of the 32-bit range
					grown = {4'd0, num_acc} * 36'd10 + {28'd0, it.ch - dldd_pkg::CH_ZERO};
					num_acc = (grown > {4'd0, dldd_pkg::VAL_MAX}) ?
						dldd_pkg::VAL_MAX : grown[31:0];
					num_open = 1'b1;
				end else if (num_open) begin
					// any non-digit byte closes an open number
					probe_set(num_acc, 1'b1);
					num_open = 1'b0;
					num_acc = '0;
				end
			end
			dldd_pkg::OP_END: begin
				if (num_open)
					probe_set(num_acc, 1'b0);
				else if (!string_started)
					probe_set('0, 1'b0);    // empty string stands for the value 0
				record_report(dldd_pkg::KIND_DONE, '0, 0, 1'b1);
				num_acc = '0;
				num_open = 1'b0;
				string_started = 1'b0;
				dup_tally = '0;
			end
			dldd_pkg::OP_CLEAR: set_fill = 0;         // open number survives a clear
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checking: the receiver never stalls, so every strobe is a transaction
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		dldd_pkg::result_t want;
		if (arst_n && strobe) begin
			if (lookup_reports.size() == 0) begin
				$error("result with nothing pending: kind %0d value %0d",
					result.kind, result.value);
				error_count++;
			end else begin
				want = lookup_reports.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("value", want.value, result.value);
				check_field("slot", 32'(want.slot), 32'(result.slot));
				check_field("dup_count", 32'(want.dup_count), 32'(result.dup_count));
				check_field("set_size", 32'(want.set_size), 32'(result.set_size));
				check_field("last", 32'(want.last), 32'(result.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one transaction; start is left high so back-to-back items keep it up
	task automatic send_item(input logic [1:0] op, input logic [7:0] c);
		dldd_pkg::item_t it;
		it.opcode = op;
		it.ch     = c;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		parse_and_lookup(it);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(dldd_pkg::OP_CHAR, s[i]);
	endtask

	// pause the sender until every owed report has come back
	task automatic wait_results_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (lookup_reports.size() != 0);
	endtask

	function automatic logic [7:0] rand_separator();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b >= dldd_pkg::CH_ZERO && b <= dldd_pkg::CH_NINE);
		return b;
	endfunction

	// mostly small values so duplicates are common; some wide and saturating ones
	function automatic string rand_number_text();
		string s;
		int unsigned len;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(20));
			5, 6: s = $sformatf("%0d", $urandom);
			7: s = $sformatf("00%0d", $urandom_range(20));
			8: s = $urandom_range(1) ? "4294967295" : "4294967296";
			default: begin
				len = $urandom_range(13, 10);
				s = "";
				for (int i = 0; i < len; i++)
					s = $sformatf("%s%0d", s, $urandom_range(9));
			end
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		send_item(dldd_pkg::OP_END, 8'hFF);            // empty string inserts 0
		send_item(dldd_pkg::OP_END, 8'h00);            // and again: now a duplicate
		send_text("99999999999");                      // saturates
		send_item(dldd_pkg::OP_END, 8'h5A);            // end closes the open number
		send_text("/007:");                            // separators next to the digit range
		send_text("9");
		send_item(dldd_pkg::OP_CHAR, 8'h00);           // nul byte is a separator too
		send_item(dldd_pkg::OP_END, dldd_pkg::CH_ZERO); // separator seen, no number: done only
		send_item(OP_UNUSED, dldd_pkg::CH_NINE);       // ignored
		send_text("3");
		send_item(dldd_pkg::OP_CLEAR, 8'hA5);          // clear keeps the number in progress
		send_item(dldd_pkg::OP_END, 8'h00);
	endtask

	// fill all slots with distinct values, then a new value and a held one
	task automatic test_set_full();
		int unsigned offset;
		offset = $urandom_range(99);
		send_item(dldd_pkg::OP_CLEAR, 8'($urandom));
		for (int i = 0; i < dldd_pkg::SET_DEPTH; i++) begin
			send_text($sformatf("%0d", (offset + i * 37) % 100));
			send_item(dldd_pkg::OP_CHAR, rand_separator());
		end
		send_text($sformatf("%0d", (offset + dldd_pkg::SET_DEPTH * 37) % 100));
		send_item(dldd_pkg::OP_CHAR, rand_separator());
		send_text($sformatf("%0d", offset));
		send_item(dldd_pkg::OP_END, 8'($urandom));
		send_item(dldd_pkg::OP_CLEAR, 8'($urandom));
	endtask

	// one long string of repeated small values so the duplicate tally wraps
	task automatic test_dup_wrap();
		send_item(dldd_pkg::OP_CLEAR, 8'($urandom));
		for (int i = 0; i < 270; i++) begin
			send_item(dldd_pkg::OP_CHAR, dldd_pkg::CH_ZERO + 8'($urandom_range(5)));
			send_item(dldd_pkg::OP_CHAR, rand_separator());
		end
		send_item(dldd_pkg::OP_END, 8'($urandom));
	endtask

	// well-formed strings with random content, plus clears, stray ends and noise
	task automatic test_random_strings(input int unsigned pct, input int unsigned n_items);
		int unsigned stop_at;
		int unsigned n_nums;
		idle_pct = pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(19))
				0: send_item(dldd_pkg::OP_CLEAR, 8'($urandom));
				1: send_item(OP_UNUSED, 8'($urandom));
				2: send_item(dldd_pkg::OP_END, 8'($urandom));
				default: begin
					n_nums = $urandom_range(4);
					if ($urandom_range(1))
						send_item(dldd_pkg::OP_CHAR, rand_separator());
					for (int i = 0; i < n_nums; i++) begin
						send_text(rand_number_text());
						if (i + 1 < n_nums || $urandom_range(1))
							send_item(dldd_pkg::OP_CHAR, rand_separator());
					end
					if ($urandom_range(9) < 8)
						send_item(dldd_pkg::OP_END, 8'($urandom));
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : run
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_results_drained();
		test_set_full();
		wait_results_drained();
		test_dup_wrap();
		wait_results_drained();

		// sender gaps: light, then heavy, then none
		test_random_strings(12, 100);
		wait_results_drained();
		test_random_strings(79, 100);
		wait_results_drained();
		test_random_strings(0, 100);
		wait_results_drained();

		// let any stray late result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
